>>> rtl/ofp_pkg.sv
`default_nettype none
package ofp_pkg;

	// fraction bits of a unit normal component
	localparam int NORM_BITS = 30;

	// configuration register indexes
	localparam logic [1:0] CFG_CAMERA_X = 2'd0;
	localparam logic [1:0] CFG_CAMERA_Y = 2'd1;
	localparam logic [1:0] CFG_CAMERA_Z = 2'd2;

	// plane indexes in output order
	localparam logic [2:0] PL_LEFT   = 3'd0;
	localparam logic [2:0] PL_RIGHT  = 3'd1;
	localparam logic [2:0] PL_TOP    = 3'd2;
	localparam logic [2:0] PL_BOTTOM = 3'd3;
	localparam logic [2:0] PL_FRONT  = 3'd4;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [32:0] diff_t;
	typedef logic signed [31:0] unorm_t;

	typedef struct packed {
		coord_t vert0_x;
		coord_t vert0_y;
		coord_t vert0_z;
		coord_t vert1_x;
		coord_t vert1_y;
		coord_t vert1_z;
		coord_t vert2_x;
		coord_t vert2_y;
		coord_t vert2_z;
		coord_t vert3_x;
		coord_t vert3_y;
		coord_t vert3_z;
	} quad_t;

	typedef struct packed {
		logic [2:0]         plane_index;
		unorm_t             plane_nx;
		unorm_t             plane_ny;
		unorm_t             plane_nz;
		logic signed [39:0] plane_offset;
		logic               camera_front_side;
		logic               degenerate;
		logic               last_plane;
	} plane_t;

	// pick one coordinate of one quad vertex
	function automatic coord_t quad_coord(input quad_t q, input logic [1:0] vi,
			input logic [1:0] ax);
		logic [11:0][31:0] flat;
		logic [3:0] pos;
		flat = q;
		pos = 4'd11 - (4'(vi) * 4'd3 + 4'(ax));
		return coord_t'(flat[pos]);
	endfunction

endpackage
`default_nettype wire

>>> rtl/occluder_frustum_plane_builder.sv
`default_nettype none
// Channel   Handshake                 Payload
// request   start / busy              quad (four vertices, Q15.16)
// result    result_valid (strobe)     result (plane, 5 per request)
// config    cfg_we, cfg_index         cfg_data (camera x, y, z)
//
// A request is taken only while busy is low; busy rises after each accept,
// set by the single result channel that carries five planes.
// Most of the latency from accept to the first plane lies in the
// bit-per-stage square root and divider of each normal unit.
// Reset clears the camera registers and all valid bits.
// Results cannot be held off; the pipeline never stalls.
module occluder_frustum_plane_builder (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  ofp_pkg::quad_t  quad,
	output logic            busy,
	input  logic            cfg_we,
	input  logic [1:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	output logic            result_valid,
	output ofp_pkg::plane_t result
);

	localparam logic [2:0] HOLD = 3'd4;

	ofp_pkg::coord_t cam_q [3];
	logic [2:0]      hold_q;
	logic            accept;

	logic            qs_valid;
	ofp_pkg::quad_t  qs_quad;
	logic            qs_front;

	assign accept = start && !busy;
	assign busy = (hold_q != '0);

	// hold off requests until the plane sequencer can take the next quad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_q <= '0;
		else if (accept)
			hold_q <= HOLD;
		else if (hold_q != '0)
			hold_q <= hold_q - 3'd1;
	end

	// camera registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == ofp_pkg::CFG_CAMERA_X)
				cam_q[0] <= ofp_pkg::coord_t'(cfg_data);
			if (cfg_index == ofp_pkg::CFG_CAMERA_Y)
				cam_q[1] <= ofp_pkg::coord_t'(cfg_data);
			if (cfg_index == ofp_pkg::CFG_CAMERA_Z)
				cam_q[2] <= ofp_pkg::coord_t'(cfg_data);
		end
	end

	ofp_quad_side u_side (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_quad  (quad),
		.cam      (cam_q),
		.out_valid(qs_valid),
		.out_quad (qs_quad),
		.out_front(qs_front)
	);

	ofp_plane_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (qs_valid),
		.in_quad     (qs_quad),
		.in_front    (qs_front),
		.cam         (cam_q),
		.result_valid(result_valid),
		.result      (result)
	);

	`ifndef SYNTH
	// an accepted request blocks the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted back to back");

	// a degenerate plane carries no normal and no offset
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.degenerate |-> result.plane_nx == '0
			&& result.plane_ny == '0 && result.plane_nz == '0
			&& result.plane_offset == '0)
		else $error("degenerate plane not zeroed");

	// planes of one quad follow in consecutive cycles
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.plane_index != ofp_pkg::PL_FRONT |=> result_valid
			&& result.plane_index == $past(result.plane_index) + 3'd1)
		else $error("plane sequence broken");
	`endif

endmodule
`default_nettype wire

>>> rtl/ofp_unit_cross.sv
`default_nettype none
module ofp_unit_cross #(
	parameter int SB_W = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  ofp_pkg::diff_t         in_a [3],
	input  ofp_pkg::diff_t         in_b [3],
	input  logic [SB_W-1:0]        in_sb,
	output logic                   out_valid,
	output ofp_pkg::unorm_t        out_n [3],
	output logic                   out_deg,
	output logic [SB_W-1:0]        out_sb
);

	localparam int SQ_STEPS = 32;
	localparam int DV_STEPS = ofp_pkg::NORM_BITS + 1;
	localparam int LAST     = SQ_STEPS + DV_STEPS;
	localparam int CHUNK    = 14;
	localparam int NCHUNK   = 5;

	function automatic logic [3:0] chunk_len(input logic [CHUNK-1:0] w);
		logic [3:0] n;
		n = '0;
		for (int b = 0; b < CHUNK; b++) begin
			if (w[b])
				n = 4'(b + 1);
		end
		return n;
	endfunction

	// front stages
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [SB_W-1:0]        sb_s1, sb_s2, sb_s3, sb_s4, sb_s5, sb_s6, sb_s7;
	logic signed [65:0]     pa_s1 [3];
	logic signed [65:0]     pb_s1 [3];
	logic signed [66:0]     c_s2 [3];
	logic [2:0][66:0]       mag_s3, mag_s4, mag_s5;
	logic [2:0]             neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [66:0]            or_s3;
	logic [NCHUNK-1:0][3:0] bl_s4;
	logic [6:0]             maxbl_s5;
	logic                   deg_s5, deg_s6, deg_s7;
	logic [2:0][30:0]       mm_s6, mm_s7;
	logic [2:0][61:0]       sqr_s7;

	logic [2:0][66:0]       mag_c;
	logic [66:0]            or_c;
	logic [69:0]            or_pad;
	logic [6:0]             maxbl_c;

	// square root and divider stages
	logic                   pv_s   [0:LAST];
	logic [SB_W-1:0]        psb_s  [0:LAST];
	logic                   pdeg_s [0:LAST];
	logic [2:0]             pneg_s [0:LAST];
	logic [63:0]            sq_rem_s  [0:SQ_STEPS];
	logic [63:0]            sq_root_s [0:SQ_STEPS];
	logic [2:0][30:0]       mm_s      [0:SQ_STEPS];
	logic [31:0]            dv_len_s [1:DV_STEPS];
	logic [2:0][31:0]       dv_rem_s [1:DV_STEPS];
	logic [2:0][30:0]       dv_q_s   [1:DV_STEPS];

	ofp_pkg::unorm_t        n_c [3];

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			pv_s[0] <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			pv_s[0] <= v_s7;
		end
	end

	// form magnitudes and their combined bit pattern
	always_comb begin
		or_c = '0;
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = c_s2[i][66] ? 67'(-c_s2[i]) : 67'(c_s2[i]);
			or_c = or_c | mag_c[i];
		end
	end

	assign or_pad = {3'b000, or_s3};

	// combine chunk lengths into the leading bit position
	always_comb begin
		maxbl_c = '0;
		for (int j = 0; j < NCHUNK; j++) begin
			if (bl_s4[j] != '0)
				maxbl_c = 7'(CHUNK * j) + 7'(bl_s4[j]);
		end
	end

	// cross product, scaling and sum of squares
	always_ff @(posedge clk) begin
		sb_s1 <= in_sb;
		pa_s1[0] <= 66'(in_a[1]) * 66'(in_b[2]);
		pb_s1[0] <= 66'(in_a[2]) * 66'(in_b[1]);
		pa_s1[1] <= 66'(in_a[2]) * 66'(in_b[0]);
		pb_s1[1] <= 66'(in_a[0]) * 66'(in_b[2]);
		pa_s1[2] <= 66'(in_a[0]) * 66'(in_b[1]);
		pb_s1[2] <= 66'(in_a[1]) * 66'(in_b[0]);

		sb_s2 <= sb_s1;
		for (int i = 0; i < 3; i++)
			c_s2[i] <= 67'(pa_s1[i]) - 67'(pb_s1[i]);

		sb_s3 <= sb_s2;
		mag_s3 <= mag_c;
		or_s3 <= or_c;
		for (int i = 0; i < 3; i++)
			neg_s3[i] <= c_s2[i][66];

		sb_s4 <= sb_s3;
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
		for (int j = 0; j < NCHUNK; j++)
			bl_s4[j] <= chunk_len(or_pad[CHUNK*j +: CHUNK]);

		sb_s5 <= sb_s4;
		mag_s5 <= mag_s4;
		neg_s5 <= neg_s4;
		maxbl_s5 <= maxbl_c;
		deg_s5 <= (maxbl_c == '0);

		sb_s6 <= sb_s5;
		neg_s6 <= neg_s5;
		deg_s6 <= deg_s5;
		for (int i = 0; i < 3; i++)
			mm_s6[i] <= 31'({mag_s5[i], 31'b0} >> maxbl_s5);

		sb_s7 <= sb_s6;
		neg_s7 <= neg_s6;
		deg_s7 <= deg_s6;
		mm_s7 <= mm_s6;
		for (int i = 0; i < 3; i++)
			sqr_s7[i] <= 62'(mm_s6[i]) * 62'(mm_s6[i]);

		psb_s[0] <= sb_s7;
		pneg_s[0] <= neg_s7;
		pdeg_s[0] <= deg_s7;
		mm_s[0] <= mm_s7;
		sq_rem_s[0] <= 64'(sqr_s7[0]) + 64'(sqr_s7[1]) + 64'(sqr_s7[2]);
		sq_root_s[0] <= '0;
	end

	// carry control and sideband along the iterative stages
	for (genvar k = 0; k < LAST; k++) begin : g_carry
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				pv_s[k+1] <= 1'b0;
			else
				pv_s[k+1] <= pv_s[k];
		end

		always_ff @(posedge clk) begin
			psb_s[k+1] <= psb_s[k];
			pneg_s[k+1] <= pneg_s[k];
			pdeg_s[k+1] <= pdeg_s[k];
		end
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
		logic [64:0] trial;

		assign trial = {1'b0, sq_root_s[k]} + {1'b0, SQ_BIT};

		always_ff @(posedge clk) begin
			if ({1'b0, sq_rem_s[k]} >= trial) begin
				sq_rem_s[k+1] <= sq_rem_s[k] - trial[63:0];
				sq_root_s[k+1] <= (sq_root_s[k] >> 1) + SQ_BIT;
			end else begin
				sq_rem_s[k+1] <= sq_rem_s[k];
				sq_root_s[k+1] <= sq_root_s[k] >> 1;
			end
			mm_s[k+1] <= mm_s[k];
		end
	end

	// divide each component by the length, one quotient bit per stage
	for (genvar j = 0; j < DV_STEPS; j++) begin : g_div
		logic [31:0]      len_in;
		logic [2:0][31:0] rem_in;
		logic [2:0][30:0] q_in;
		logic [2:0][32:0] part;

		if (j == 0) begin : g_first
			assign len_in = sq_root_s[SQ_STEPS][31:0];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_in[i] = {1'b0, mm_s[SQ_STEPS][i]};
			end
			assign q_in = '0;
		end else begin : g_next
			assign len_in = dv_len_s[j];
			assign rem_in = dv_rem_s[j];
			assign q_in = dv_q_s[j];
		end

		always_comb begin
			for (int i = 0; i < 3; i++)
				part[i] = (j == 0) ? {1'b0, rem_in[i]} : {rem_in[i], 1'b0};
		end

		always_ff @(posedge clk) begin
			dv_len_s[j+1] <= len_in;
			for (int i = 0; i < 3; i++) begin
				if (part[i] >= {1'b0, len_in}) begin
					dv_rem_s[j+1][i] <= 32'(part[i] - {1'b0, len_in});
					dv_q_s[j+1][i] <= {q_in[i][29:0], 1'b1};
				end else begin
					dv_rem_s[j+1][i] <= part[i][31:0];
					dv_q_s[j+1][i] <= {q_in[i][29:0], 1'b0};
				end
			end
		end
	end

	// restore signs, zero a degenerate normal
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (pdeg_s[LAST])
				n_c[i] = '0;
			else if (pneg_s[LAST][i])
				n_c[i] = ofp_pkg::unorm_t'(-{1'b0, dv_q_s[DV_STEPS][i]});
			else
				n_c[i] = ofp_pkg::unorm_t'({1'b0, dv_q_s[DV_STEPS][i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else
			out_valid <= pv_s[LAST];
	end

	always_ff @(posedge clk) begin
		out_sb <= psb_s[LAST];
		out_deg <= pdeg_s[LAST];
		for (int i = 0; i < 3; i++)
			out_n[i] <= n_c[i];
	end

endmodule
`default_nettype wire

>>> rtl/ofp_quad_side.sv
`default_nettype none
module ofp_quad_side (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  ofp_pkg::quad_t  in_quad,
	input  ofp_pkg::coord_t cam [3],
	output logic            out_valid,
	output ofp_pkg::quad_t  out_quad,
	output logic            out_front
);

	typedef struct packed {
		ofp_pkg::quad_t       quad;
		logic [2:0][32:0]     dc;
	} qside_sb_t;

	localparam int SB_W = $bits(qside_sb_t);

	logic               v_s1;
	ofp_pkg::quad_t     quad_s1;
	ofp_pkg::diff_t     e1_s1 [3];
	ofp_pkg::diff_t     e2_s1 [3];
	logic [2:0][32:0]   dc_s1;
	qside_sb_t          sb_in;

	logic               u_valid;
	ofp_pkg::unorm_t    u_n [3];
	logic               u_deg;
	logic [SB_W-1:0]    u_sb;
	qside_sb_t          u_side;

	logic               v_s2, v_s3;
	ofp_pkg::quad_t     quad_s2, quad_s3;
	logic signed [64:0] prod_s2 [3];
	logic               front_s3;
	logic signed [66:0] dot_c;

	// register edge vectors and camera offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		quad_s1 <= in_quad;
		for (int k = 0; k < 3; k++) begin
			e1_s1[k] <= 33'(ofp_pkg::quad_coord(in_quad, 2'd1, 2'(k)))
				- 33'(ofp_pkg::quad_coord(in_quad, 2'd0, 2'(k)));
			e2_s1[k] <= 33'(ofp_pkg::quad_coord(in_quad, 2'd3, 2'(k)))
				- 33'(ofp_pkg::quad_coord(in_quad, 2'd0, 2'(k)));
			dc_s1[k] <= 33'(cam[k]) - 33'(ofp_pkg::quad_coord(in_quad, 2'd0, 2'(k)));
		end
	end

	assign sb_in.quad = quad_s1;
	assign sb_in.dc = dc_s1;

	ofp_unit_cross #(
		.SB_W(SB_W)
	) u_normal (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.in_a     (e1_s1),
		.in_b     (e2_s1),
		.in_sb    (SB_W'(sb_in)),
		.out_valid(u_valid),
		.out_n    (u_n),
		.out_deg  (u_deg),
		.out_sb   (u_sb)
	);

	assign u_side = qside_sb_t'(u_sb);

	assign dot_c = 67'(prod_s2[0]) + 67'(prod_s2[1]) + 67'(prod_s2[2]);

	// camera side test against the unit quad normal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= u_valid;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		quad_s2 <= u_side.quad;
		for (int k = 0; k < 3; k++)
			prod_s2[k] <= 65'($signed(u_side.dc[k])) * 65'(u_n[k]);
		quad_s3 <= quad_s2;
		front_s3 <= !dot_c[66];
	end

	assign out_valid = v_s3;
	assign out_quad = quad_s3;
	assign out_front = front_s3;

	`ifndef SYNTH
	// a degenerate quad normal zeroes it before the side test
	assert property (@(posedge clk) disable iff (!arst_n)
		u_valid && u_deg |-> u_n[0] == '0 && u_n[1] == '0 && u_n[2] == '0)
		else $error("degenerate quad normal not zeroed");
	`endif

endmodule
`default_nettype wire

>>> rtl/ofp_plane_seq.sv
`default_nettype none
module ofp_plane_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  ofp_pkg::quad_t  in_quad,
	input  logic            in_front,
	input  ofp_pkg::coord_t cam [3],
	output logic            result_valid,
	output ofp_pkg::plane_t result
);

	typedef struct packed {
		logic [2:0]       idx;
		logic             front;
		logic [2:0][31:0] pt;
	} job_sb_t;

	localparam int SB_W = $bits(job_sb_t);
	localparam logic [1:0] PAIR_A [4] = '{2'd0, 2'd2, 2'd1, 2'd3};
	localparam logic [1:0] PAIR_B [4] = '{2'd1, 2'd3, 2'd2, 2'd0};

	logic               act_q;
	logic [2:0]         cnt_q;
	ofp_pkg::quad_t     quad_q;
	logic               front_q;

	logic [1:0]         ia, ib;
	ofp_pkg::diff_t     ja [3];
	ofp_pkg::diff_t     jb [3];
	logic [2:0][31:0]   jp;
	ofp_pkg::diff_t     d2, d3;

	logic               jv_s1;
	ofp_pkg::diff_t     ja_s1 [3];
	ofp_pkg::diff_t     jb_s1 [3];
	job_sb_t            jsb_s1;

	logic               u_valid;
	ofp_pkg::unorm_t    u_n [3];
	logic               u_deg;
	logic [SB_W-1:0]    u_sb;
	job_sb_t            u_job;

	logic               v_o1;
	ofp_pkg::unorm_t    n_o1 [3];
	logic signed [63:0] prod_o1 [3];
	job_sb_t            job_o1;
	logic               deg_o1;
	logic signed [65:0] dot_c;
	logic signed [35:0] q_c;
	logic signed [39:0] ofs_c;

	// step through the five planes of the held quad
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			cnt_q <= ofp_pkg::PL_LEFT;
		end else if (in_valid) begin
			act_q <= 1'b1;
			cnt_q <= ofp_pkg::PL_LEFT;
		end else if (act_q) begin
			if (cnt_q == ofp_pkg::PL_FRONT)
				act_q <= 1'b0;
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			quad_q <= in_quad;
			front_q <= in_front;
		end
	end

	// build both edge vectors and the point of the current plane
	always_comb begin
		ia = front_q ? PAIR_A[cnt_q[1:0]] : PAIR_B[cnt_q[1:0]];
		ib = front_q ? PAIR_B[cnt_q[1:0]] : PAIR_A[cnt_q[1:0]];
		d2 = '0;
		d3 = '0;
		for (int k = 0; k < 3; k++) begin
			if (cnt_q == ofp_pkg::PL_FRONT) begin
				d2 = 33'(ofp_pkg::quad_coord(quad_q, 2'd2, 2'(k)))
					- 33'(ofp_pkg::quad_coord(quad_q, 2'd0, 2'(k)));
				d3 = 33'(ofp_pkg::quad_coord(quad_q, 2'd3, 2'(k)))
					- 33'(ofp_pkg::quad_coord(quad_q, 2'd0, 2'(k)));
				ja[k] = front_q ? d2 : d3;
				jb[k] = front_q ? d3 : d2;
				jp[k] = ofp_pkg::quad_coord(quad_q, 2'd0, 2'(k));
			end else begin
				ja[k] = 33'(ofp_pkg::quad_coord(quad_q, ia, 2'(k))) - 33'(cam[k]);
				jb[k] = 33'(ofp_pkg::quad_coord(quad_q, ib, 2'(k))) - 33'(cam[k]);
				jp[k] = cam[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			jv_s1 <= 1'b0;
		else
			jv_s1 <= act_q;
	end

	always_ff @(posedge clk) begin
		ja_s1 <= ja;
		jb_s1 <= jb;
		jsb_s1.idx <= cnt_q;
		jsb_s1.front <= front_q;
		jsb_s1.pt <= jp;
	end

	ofp_unit_cross #(
		.SB_W(SB_W)
	) u_plane (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (jv_s1),
		.in_a     (ja_s1),
		.in_b     (jb_s1),
		.in_sb    (SB_W'(jsb_s1)),
		.out_valid(u_valid),
		.out_n    (u_n),
		.out_deg  (u_deg),
		.out_sb   (u_sb)
	);

	assign u_job = job_sb_t'(u_sb);

	// offset: round the dot product to nearest, ties up, then negate
	assign dot_c = 66'(prod_o1[0]) + 66'(prod_o1[1]) + 66'(prod_o1[2])
		+ (66'sd1 <<< (ofp_pkg::NORM_BITS - 1));
	assign q_c = 36'(dot_c >>> ofp_pkg::NORM_BITS);
	// the rounded value always fits the 40-bit field
	assign ofs_c = -(40'(q_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o1 <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			v_o1 <= u_valid;
			result_valid <= v_o1;
		end
	end

	always_ff @(posedge clk) begin
		n_o1 <= u_n;
		job_o1 <= u_job;
		deg_o1 <= u_deg;
		for (int k = 0; k < 3; k++)
			prod_o1[k] <= 64'(u_n[k]) * 64'($signed(u_job.pt[k]));

		result.plane_index <= job_o1.idx;
		result.plane_nx <= n_o1[0];
		result.plane_ny <= n_o1[1];
		result.plane_nz <= n_o1[2];
		result.plane_offset <= deg_o1 ? '0 : ofs_c;
		result.camera_front_side <= job_o1.front;
		result.degenerate <= deg_o1;
		result.last_plane <= (job_o1.idx == ofp_pkg::PL_FRONT);
	end

	`ifndef SYNTH
	// a new quad never arrives while planes of the last one remain
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !act_q || cnt_q == ofp_pkg::PL_FRONT)
		else $error("quad arrived while sequencer busy");
	`endif

endmodule
`default_nettype wire
